/* hdl/cch_pkg.sv */
// Shared types, constants and helper functions of the coupon collector histogram core.
`timescale 1ns / 1ps

package cch_pkg;

   localparam int CCH_MAX_CATEGORIES = 10;
   localparam int CCH_COUNT_WIDTH    = 16;

   localparam int CAT_W          = 4;
   localparam int VALUE_W        = 4;
   localparam int DRAW_W         = 8;
   localparam int TRIAL_W        = 16;
   localparam int VWIDTH_W       = 3;
   localparam int MIN_CATEGORIES = 3;
   localparam int VALUE_STEPS    = 5;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 16;

   localparam logic [CAT_W-1:0]   NUM_CATEGORIES_RESET = 4'd5;
   localparam logic [TRIAL_W-1:0] MAX_TRIALS_RESET     = 16'd10000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUM_CATEGORIES = 1'b0,
      CSR_MAX_TRIALS     = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_SHIFT,
      ST_WRITE,
      ST_EMIT
   } state_type;

   // smallest b >= 1 with 2^b >= d
   function automatic logic [VWIDTH_W-1:0] value_width(input logic [CAT_W-1:0] d);
      logic [VWIDTH_W-1:0] b;
      b = 3'd1;
      for (int i = 1; i < VALUE_W; i++) begin
         if ((5'd1 << b) < {1'b0, d}) begin
            b = b + 3'd1;
         end
      end
      return b;
   endfunction

   // value mod d for a 4-bit value and d >= 3: at most five subtractions
   function automatic logic [CAT_W-1:0] category_of(input logic [VALUE_W-1:0] value,
                                                    input logic [CAT_W-1:0] d);
      logic [VALUE_W-1:0] r;
      r = value;
      for (int i = 0; i < VALUE_STEPS; i++) begin
         if (r >= d) begin
            r = r - d;
         end
      end
      return r;
   endfunction

endpackage

/* hdl/coupon_collector_histogram_core.sv */
// Top level of the coupon collector histogram core: bit packing, coupon tracking, histogram.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  req_bit_value, req_last_bit
//   rsp_     out        rsp_valid/rsp_stall  trial_complete, bin_index, draw_count,
//                                            bin_total, trials_done, limit_reached, stream_end
//   csr_     in         csr_write            csr_index, csr_data
//
// A bit that ends no trial stays in ST_IDLE; a last bit without one also passes ST_EMIT.
// A completed trial passes ST_READ, ST_LOAD, ST_SHIFT, ST_WRITE and ST_EMIT: the bin count
// and trial counter step one bit per cycle in shift registers, with a RAM read and a write.
// Reset is synchronous; histogram bins are tracked by valid flags, so no clearing pass.
// A waiting response does not hold off bits that produce none; a new response waits for it.
`timescale 1ns / 1ps

module coupon_collector_histogram_core
   import cch_pkg::*;
#(
   parameter int MAX_CATEGORIES = CCH_MAX_CATEGORIES,
   parameter int COUNT_WIDTH    = CCH_COUNT_WIDTH,
   localparam int NUM_BINS      = 2 * MAX_CATEGORIES + 1,
   localparam int BIN_W         = $clog2(NUM_BINS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_bit_value,
   input  logic                     req_last_bit,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_trial_complete,
   output logic [BIN_W-1:0]         rsp_bin_index,
   output logic [DRAW_W-1:0]        rsp_draw_count,
   output logic [COUNT_WIDTH-1:0]   rsp_bin_total,
   output logic [TRIAL_W-1:0]       rsp_trials_done,
   output logic                     rsp_limit_reached,
   output logic                     rsp_stream_end,
   input  logic                     csr_write,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   localparam int VW      = $clog2(MAX_CATEGORIES);
   localparam int POS_W   = $clog2(VW);
   localparam int SER_LEN = (COUNT_WIDTH > TRIAL_W) ? COUNT_WIDTH : TRIAL_W;
   localparam int CNT_W   = $clog2(SER_LEN);

   // control state
   state_type               state_ff, state_in;
   logic [CAT_W-1:0]        num_cat_ff, num_cat_in;
   logic [TRIAL_W-1:0]      max_trials_ff, max_trials_in;
   logic [VW-1:0]           value_ff, value_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [MAX_CATEGORIES-1:0] seen_ff, seen_in;
   logic [DRAW_W-1:0]       draws_ff, draws_in;
   logic [TRIAL_W-1:0]      completed_ff, completed_in;
   logic [NUM_BINS-1:0]     hist_valid_ff, hist_valid_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // payload
   logic [BIN_W-1:0]        bin_ff, bin_in;
   logic [DRAW_W-1:0]       dcount_ff, dcount_in;
   logic [COUNT_WIDTH-1:0]  bin_sh_ff, bin_sh_in;
   logic                    bin_c_ff, bin_c_in;
   logic                    trial_c_ff, trial_c_in;
   logic                    done_ff, done_in;
   logic                    last_ff, last_in;
   logic                    out_complete_ff, out_complete_in;
   logic [BIN_W-1:0]        out_bin_ff, out_bin_in;
   logic [DRAW_W-1:0]       out_draws_ff, out_draws_in;
   logic [COUNT_WIDTH-1:0]  out_total_ff, out_total_in;
   logic [TRIAL_W-1:0]      out_trials_ff, out_trials_in;
   logic                    out_limit_ff, out_limit_in;
   logic                    out_end_ff, out_end_in;

   // datapath of one accepted bit
   logic [CAT_W-1:0]          d;
   logic                      limit;
   logic [VW-1:0]             value_shift;
   logic [POS_W:0]            pos_inc;
   logic                      value_done;
   logic [CAT_W-1:0]          cat;
   logic [MAX_CATEGORIES-1:0] seen_new;
   logic                      set_full;
   logic [DRAW_W-1:0]         draws_sat;
   logic [DRAW_W-1:0]         diff;
   logic [DRAW_W-1:0]         bin_lim;
   logic [DRAW_W-1:0]         bin8;
   logic                      trial_done;

   logic                    ram_wr_en;
   logic [COUNT_WIDTH-1:0]  ram_wr_data;
   logic [COUNT_WIDTH-1:0]  ram_rd_data;

   cch_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (NUM_BINS)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (bin_ff),
      .wr_data (ram_wr_data),
      .rd_addr (bin_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (num_cat_ff < CAT_W'(MIN_CATEGORIES)) begin
         d = CAT_W'(MIN_CATEGORIES);
      end else if ({1'b0, num_cat_ff} > (CAT_W+1)'(MAX_CATEGORIES)) begin
         d = CAT_W'(MAX_CATEGORIES);
      end else begin
         d = num_cat_ff;
      end
   end

   assign limit       = completed_ff >= max_trials_ff;
   assign value_shift = {value_ff[VW-2:0], req_bit_value};
   assign pos_inc     = {1'b0, pos_ff} + 1'b1;
   assign value_done  = VWIDTH_W'(pos_inc) >= value_width(d);
   assign cat         = category_of(VALUE_W'(value_shift), d);
   assign draws_sat   = (draws_ff == '1) ? draws_ff : draws_ff + 1'b1;

   always_comb begin
      set_full = 1'b1;
      for (int i = 0; i < MAX_CATEGORIES; i++) begin
         seen_new[i] = seen_ff[i] | (cat == CAT_W'(i));
         if (!seen_new[i] && ((CAT_W+1)'(i) < {1'b0, d})) begin
            set_full = 1'b0;
         end
      end
   end

   // bin = draws - d, clamped to 0..2d
   assign diff       = (draws_sat >= DRAW_W'(d)) ? draws_sat - DRAW_W'(d) : '0;
   assign bin_lim    = DRAW_W'({d, 1'b0});
   assign bin8       = (diff > bin_lim) ? bin_lim : diff;
   assign trial_done = !limit && value_done && set_full;

   always_comb begin
      state_in        = state_ff;
      num_cat_in      = num_cat_ff;
      max_trials_in   = max_trials_ff;
      value_in        = value_ff;
      pos_in          = pos_ff;
      seen_in         = seen_ff;
      draws_in        = draws_ff;
      completed_in    = completed_ff;
      hist_valid_in   = hist_valid_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff;
      bin_in          = bin_ff;
      dcount_in       = dcount_ff;
      bin_sh_in       = bin_sh_ff;
      bin_c_in        = bin_c_ff;
      trial_c_in      = trial_c_ff;
      done_in         = done_ff;
      last_in         = last_ff;
      out_complete_in = out_complete_ff;
      out_bin_in      = out_bin_ff;
      out_draws_in    = out_draws_ff;
      out_total_in    = out_total_ff;
      out_trials_in   = out_trials_ff;
      out_limit_in    = out_limit_ff;
      out_end_in      = out_end_ff;
      ram_wr_en       = 1'b0;
      ram_wr_data     = bin_sh_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_NUM_CATEGORIES: num_cat_in = csr_data[CAT_W-1:0];
            CSR_MAX_TRIALS:     max_trials_in = csr_data[TRIAL_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!limit) begin
                  value_in = value_shift;
                  pos_in   = pos_inc[POS_W-1:0];
                  if (value_done) begin
                     value_in = '0;
                     pos_in   = '0;
                     draws_in = draws_sat;
                     seen_in  = seen_new;
                     if (set_full) begin
                        seen_in   = '0;
                        draws_in  = '0;
                        bin_in    = BIN_W'(bin8);
                        dcount_in = draws_sat;
                     end
                  end
               end
               done_in = trial_done;
               last_in = req_last_bit;
               if (trial_done) begin
                  state_in = ST_READ;
               end else if (req_last_bit) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            bin_sh_in  = hist_valid_ff[bin_ff] ? ram_rd_data : '0;
            bin_c_in   = 1'b1;
            trial_c_in = 1'b1;
            cnt_in     = '0;
            state_in   = ST_SHIFT;
         end
         ST_SHIFT: begin
            // serial increment, LSB first; the carry left over marks saturation
            if ({1'b0, cnt_ff} < (CNT_W+1)'(COUNT_WIDTH)) begin
               bin_sh_in = {bin_sh_ff[0] ^ bin_c_ff, bin_sh_ff[COUNT_WIDTH-1:1]};
               bin_c_in  = bin_sh_ff[0] & bin_c_ff;
            end
            if ({1'b0, cnt_ff} < (CNT_W+1)'(TRIAL_W)) begin
               completed_in = {completed_ff[0] ^ trial_c_ff, completed_ff[TRIAL_W-1:1]};
               trial_c_in   = completed_ff[0] & trial_c_ff;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SER_LEN - 1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            bin_sh_in             = bin_c_ff ? '1 : bin_sh_ff;
            completed_in          = trial_c_ff ? '1 : completed_ff;
            ram_wr_en             = 1'b1;
            ram_wr_data           = bin_sh_in;
            hist_valid_in[bin_ff] = 1'b1;
            state_in              = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               out_complete_in = done_ff;
               out_bin_in      = done_ff ? bin_ff : '0;
               out_draws_in    = done_ff ? dcount_ff : '0;
               out_total_in    = done_ff ? bin_sh_ff : '0;
               out_trials_in   = completed_ff;
               out_limit_in    = limit;
               out_end_in      = last_ff;
               if (last_ff) begin
                  value_in      = '0;
                  pos_in        = '0;
                  seen_in       = '0;
                  draws_in      = '0;
                  completed_in  = '0;
                  hist_valid_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_cat_ff    <= NUM_CATEGORIES_RESET;
         max_trials_ff <= MAX_TRIALS_RESET;
         value_ff      <= '0;
         pos_ff        <= '0;
         seen_ff       <= '0;
         draws_ff      <= '0;
         completed_ff  <= '0;
         hist_valid_ff <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_cat_ff    <= num_cat_in;
         max_trials_ff <= max_trials_in;
         value_ff      <= value_in;
         pos_ff        <= pos_in;
         seen_ff       <= seen_in;
         draws_ff      <= draws_in;
         completed_ff  <= completed_in;
         hist_valid_ff <= hist_valid_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff          <= bin_in;
      dcount_ff       <= dcount_in;
      bin_sh_ff       <= bin_sh_in;
      bin_c_ff        <= bin_c_in;
      trial_c_ff      <= trial_c_in;
      done_ff         <= done_in;
      last_ff         <= last_in;
      out_complete_ff <= out_complete_in;
      out_bin_ff      <= out_bin_in;
      out_draws_ff    <= out_draws_in;
      out_total_ff    <= out_total_in;
      out_trials_ff   <= out_trials_in;
      out_limit_ff    <= out_limit_in;
      out_end_ff      <= out_end_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_trial_complete = out_complete_ff;
   assign rsp_bin_index      = out_bin_ff;
   assign rsp_draw_count     = out_draws_ff;
   assign rsp_bin_total      = out_total_ff;
   assign rsp_trials_done    = out_trials_ff;
   assign rsp_limit_reached  = out_limit_ff;
   assign rsp_stream_end     = out_end_ff;

endmodule

/* hdl/cch_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cch_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 21
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* bench/coupon_collector_histogram_core_tb.sv */
// Self-checking testbench for the coupon collector histogram core.
`timescale 1ns / 1ps

module coupon_collector_histogram_core_tb
   import cch_pkg::*;
();

   localparam int NUM_BINS       = 2 * CCH_MAX_CATEGORIES + 1;
   localparam int BIN_W          = $clog2(NUM_BINS);
   localparam int SETTLE_CYCLES  = 32;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 400;
   localparam int STARVE_DRAWS   = 260;
   localparam int PLAN_LEN       = 29;
   localparam int NUM_PHASES     = 9;
   localparam int NUM_FIELDS     = 7;

   typedef struct packed {
      logic                       trial_complete;
      logic [BIN_W-1:0]           bin_index;
      logic [DRAW_W-1:0]          draw_count;
      logic [CCH_COUNT_WIDTH-1:0] bin_total;
      logic [TRIAL_W-1:0]         trials_done;
      logic                       limit_reached;
      logic                       stream_end;
   } trial_report_type;

   typedef enum logic {
      ROW_BIT,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      csr_index_type         index;
      logic [CSR_DATA_W-1:0] data;
      logic                  bit_value;
      logic                  last_bit;
      logic                  typed;
      trial_report_type      report;
   } plan_row_type;

   typedef struct packed {
      int categories;
      int max_trials;
      int idle;
      int stall;
      int items;
      int last_per_mille;
      bit starve;
      bit hold;
   } phase_type;

   logic                       clock;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_stall;
   logic                       req_bit_value = 1'b0;
   logic                       req_last_bit  = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall     = 1'b0;
   logic                       rsp_trial_complete;
   logic [BIN_W-1:0]           rsp_bin_index;
   logic [DRAW_W-1:0]          rsp_draw_count;
   logic [CCH_COUNT_WIDTH-1:0] rsp_bin_total;
   logic [TRIAL_W-1:0]         rsp_trials_done;
   logic                       rsp_limit_reached;
   logic                       rsp_stream_end;
   logic                       csr_write     = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index     = CSR_NUM_CATEGORIES;
   logic [CSR_DATA_W-1:0]      csr_data      = '0;

   coupon_collector_histogram_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_bit_value      (req_bit_value),
      .req_last_bit       (req_last_bit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_trial_complete (rsp_trial_complete),
      .rsp_bin_index      (rsp_bin_index),
      .rsp_draw_count     (rsp_draw_count),
      .rsp_bin_total      (rsp_bin_total),
      .rsp_trials_done    (rsp_trials_done),
      .rsp_limit_reached  (rsp_limit_reached),
      .rsp_stream_end     (rsp_stream_end),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // predictor state
   logic [CAT_W-1:0]           cfg_categories;
   logic [TRIAL_W-1:0]         cfg_max_trials;
   logic [VALUE_W-1:0]         pk_value;
   int                         pk_position;
   logic [15:0]                seen_cats;
   logic [DRAW_W-1:0]          draws_so_far;
   logic [CCH_COUNT_WIDTH-1:0] bin_counts [NUM_BINS];
   logic [TRIAL_W-1:0]         trials_so_far;

   trial_report_type pending_reports [$];
   plan_row_type     plan [PLAN_LEN];
   phase_type        phases [NUM_PHASES];
   string            field_names [NUM_FIELDS] = '{"trial_complete", "bin_index", "draw_count",
                                                  "bin_total", "trials_done", "limit_reached",
                                                  "stream_end"};

   int idle_pct = 0;
   int stall_pct = 0;
   int hold_tickets = 0;
   int hold_taken = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int mismatches = 0;
   int n_requests = 0;
   int n_reports = 0;
   int n_trials = 0;
   int n_ends = 0;
   int n_writes = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int category_count();
      int d;
      d = cfg_categories;
      if (d < MIN_CATEGORIES) d = MIN_CATEGORIES;
      if (d > CCH_MAX_CATEGORIES) d = CCH_MAX_CATEGORIES;
      return d;
   endfunction

   function automatic int draw_bits(input int d);
      int w;
      w = 1;
      while (w < 5 && (1 << w) < d) w++;
      return w;
   endfunction

   function automatic void restart_stream();
      pk_value = '0;
      pk_position = 0;
      seen_cats = '0;
      draws_so_far = '0;
      foreach (bin_counts[i]) bin_counts[i] = '0;
      trials_so_far = '0;
   endfunction

   // Advances the coupon state by one stream bit; returns 1 when a report is due.
   function automatic bit tally_bit(input logic b, input logic l, output trial_report_type rpt);
      int d, w, cat, bin;
      logic [15:0] full;
      bit done;
      d = category_count();
      w = draw_bits(d);
      full = 16'((1 << d) - 1);
      done = 1'b0;
      rpt = '0;
      if (trials_so_far < cfg_max_trials) begin
         pk_value = {pk_value[VALUE_W-2:0], b};
         pk_position++;
         if (pk_position >= w) begin
            cat = int'(pk_value) % d;
            pk_value = '0;
            pk_position = 0;
            if (draws_so_far != '1) draws_so_far++;
            seen_cats |= 16'(1 << cat);
            if ((seen_cats & full) == full) begin
               bin = (int'(draws_so_far) >= d) ? int'(draws_so_far) - d : 0;
               if (bin > 2 * d) bin = 2 * d;
               if (bin_counts[bin] != '1) bin_counts[bin]++;
               if (trials_so_far != '1) trials_so_far++;
               rpt.trial_complete = 1'b1;
               rpt.bin_index = BIN_W'(bin);
               rpt.draw_count = draws_so_far;
               rpt.bin_total = bin_counts[bin];
               seen_cats = '0;
               draws_so_far = '0;
               done = 1'b1;
            end
         end
      end
      rpt.trials_done = trials_so_far;
      rpt.limit_reached = trials_so_far >= cfg_max_trials;
      rpt.stream_end = l;
      if (l) restart_stream();
      return done || l;
   endfunction

   function automatic plan_row_type bit_row(input logic b, input logic l);
      plan_row_type r;
      r = '0;
      r.kind = ROW_BIT;
      r.bit_value = b;
      r.last_bit = l;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input csr_index_type idx,
                                            input logic [CSR_DATA_W-1:0] data);
      plan_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.index = idx;
      r.data = data;
      return r;
   endfunction

   // last bit that completes no trial: only the stream counters are nonzero
   function automatic plan_row_type closing_row(input logic b, input logic [TRIAL_W-1:0] trials,
                                                input logic limit);
      plan_row_type r;
      r = bit_row(b, 1'b1);
      r.typed = 1'b1;
      r.report.trials_done = trials;
      r.report.limit_reached = limit;
      r.report.stream_end = 1'b1;
      return r;
   endfunction

   task automatic offer_bit(input logic b, input logic l, input bit typed,
                            input trial_report_type typed_rpt);
      trial_report_type rpt;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_bit_value <= b;
      req_last_bit <= l;
      do @(posedge clock); while (req_stall);
      n_requests++;
      if (tally_bit(b, l, rpt)) pending_reports.push_back(typed ? typed_rpt : rpt);
   endtask

   // block idle: no report outstanding and any trailing bits absorbed
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      n_writes++;
      case (idx)
         CSR_NUM_CATEGORIES: cfg_categories = data[CAT_W-1:0];
         default: cfg_max_trials = data[TRIAL_W-1:0];
      endcase
   endtask

   // response side: random stall, or a long hold when one is requested
   always @(posedge clock) begin
      if (hold_tickets != hold_taken) begin
         hold_taken = hold_tickets;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else
         rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      trial_report_type got;
      trial_report_type want;
      logic [31:0] want_f [NUM_FIELDS];
      logic [31:0] got_f [NUM_FIELDS];
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_trial_complete, rsp_bin_index, rsp_draw_count, rsp_bin_total,
                rsp_trials_done, rsp_limit_reached, rsp_stream_end};
         n_reports++;
         if (got.trial_complete) n_trials++;
         if (got.stream_end) n_ends++;
         if (pending_reports.size() == 0) begin
            mismatches++;
            $display("%0t: report expected none got %h", $time, got);
         end else begin
            want = pending_reports.pop_front();
            want_f = '{want.trial_complete, want.bin_index, want.draw_count, want.bin_total,
                       want.trials_done, want.limit_reached, want.stream_end};
            got_f = '{got.trial_complete, got.bin_index, got.draw_count, got.bin_total,
                      got.trials_done, got.limit_reached, got.stream_end};
            for (int i = 0; i < NUM_FIELDS; i++) begin
               if (want_f[i] !== got_f[i]) begin
                  mismatches++;
                  $display("%0t: %s expected %0d got %0d", $time, field_names[i],
                           want_f[i], got_f[i]);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d reports outstanding", $time,
                  quiet_cycles, pending_reports.size());
         $display("CHECK FAILED");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      int d;
      int w;
      int v;
      logic [CSR_DATA_W-1:0] csr_word;

      plan = '{
         closing_row(1'b1, 16'd0, 1'b0),
         csr_row(CSR_NUM_CATEGORIES, 16'd0),      // below range, runs as 3
         csr_row(CSR_MAX_TRIALS, 16'd1),
         bit_row(1'b0, 1'b0), bit_row(1'b0, 1'b0),
         bit_row(1'b0, 1'b0), bit_row(1'b1, 1'b0),
         bit_row(1'b1, 1'b0), bit_row(1'b1, 1'b0), // 3 folds onto category 0
         bit_row(1'b1, 1'b0), bit_row(1'b0, 1'b0), // set complete, limit reached
         bit_row(1'b1, 1'b0), bit_row(1'b1, 1'b0), // ignored past the limit
         closing_row(1'b0, 16'd1, 1'b1),
         csr_row(CSR_MAX_TRIALS, 16'd0),          // limit holds from the start
         closing_row(1'b1, 16'd0, 1'b1),
         csr_row(CSR_MAX_TRIALS, 16'hFFFF),
         csr_row(CSR_NUM_CATEGORIES, 16'd2),
         bit_row(1'b0, 1'b0), bit_row(1'b0, 1'b0),
         bit_row(1'b0, 1'b0), bit_row(1'b1, 1'b0),
         bit_row(1'b1, 1'b0), bit_row(1'b0, 1'b1), // last bit completes the set
         csr_row(CSR_NUM_CATEGORIES, 16'hFFFF),   // 15 clamps to 10
         bit_row(1'b1, 1'b0), bit_row(1'b1, 1'b0),
         bit_row(1'b1, 1'b0), closing_row(1'b1, 16'd0, 1'b0)
      };

      // categories, max trials, idle %, stall %, items, last per mille, starve, hold
      phases = '{
         '{1, 65535, 17, 69, 120, 12, 1'b1, 1'b0},
         '{3, 7, 17, 69, 100, 5, 1'b0, 1'b0},
         '{7, 300, 69, 17, 180, 16, 1'b0, 1'b0},
         '{4, 2, 69, 17, 100, 25, 1'b0, 1'b0},
         '{5, 65535, 0, 0, 220, 6, 1'b0, 1'b1},
         '{10, 1000, 0, 0, 180, 5, 1'b0, 1'b0},
         '{9, 10000, 0, 0, 120, 14, 1'b0, 1'b0},
         '{8, 40, 0, 0, 120, 10, 1'b0, 1'b0},
         '{6, 65535, 0, 0, 80, 20, 1'b0, 1'b0}
      };

      cfg_categories = NUM_CATEGORIES_RESET;
      cfg_max_trials = MAX_TRIALS_RESET;
      restart_stream();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 17;
      stall_pct <= 69;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            write_reg(plan[i].index, plan[i].data);
         end else
            offer_bit(plan[i].bit_value, plan[i].last_bit, plan[i].typed, plan[i].report);
      end

      // no last bit between phases: register changes land on a live stream
      foreach (phases[p]) begin
         settle();
         csr_word = CSR_DATA_W'($urandom);
         csr_word[CAT_W-1:0] = phases[p].categories[CAT_W-1:0];
         write_reg(CSR_NUM_CATEGORIES, csr_word);
         write_reg(CSR_MAX_TRIALS, phases[p].max_trials[CSR_DATA_W-1:0]);
         idle_pct = phases[p].idle;
         stall_pct <= phases[p].stall;
         if (phases[p].hold) hold_tickets <= hold_tickets + 1;
         if (phases[p].starve) begin
            // withhold category 0 long enough to saturate the draw counter
            d = category_count();
            w = draw_bits(d);
            offer_bit(1'b0, 1'b1, 1'b0, '0);
            for (int n = 0; n <= STARVE_DRAWS; n++) begin
               if (n == STARVE_DRAWS) begin
                  v = 0;
               end else begin
                  do v = $urandom_range((1 << w) - 1); while (v % d == 0);
               end
               for (int k = w - 1; k >= 0; k--) offer_bit(v[k], 1'b0, 1'b0, '0);
            end
         end
         repeat (phases[p].items)
            offer_bit(1'($urandom_range(1)), $urandom_range(999) < phases[p].last_per_mille,
                      1'b0, '0);
      end

      settle();
      $display("%0d requests, %0d register writes, %0d reports (%0d completed trials, %0d ends)",
               n_requests, n_writes, n_reports, n_trials, n_ends);
      $display("categories 3..10 with clamped settings, trial limits 0..65535, saturated draws");
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* files.f */
hdl/cch_pkg.sv
hdl/cch_ram.sv
hdl/coupon_collector_histogram_core.sv
bench/coupon_collector_histogram_core_tb.sv
